// ----- hdl/ddsc_pkg.sv -----
`timescale 1ns / 1ps

package ddsc_pkg;

  // Field widths
  localparam int SAMPLE_W   = 12;
  localparam int AVG_W      = 12;
  localparam int TICK_W     = 10;
  localparam int TICKS_W    = 16;
  localparam int PWM_W      = 8;
  localparam int BASE_W     = 16;
  localparam int GAIN_W     = 12;
  localparam int OFFSET_W   = 8;
  localparam int DELTA_W    = 18;
  localparam int PHASE_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int COUNT_BITS_DEF = 16;
  localparam int JOLT_TICKS     = 2;

  // Encoder averaging and hysteresis
  localparam int SUM_W      = 16;            // 3*avg + 7*sample < 2^16
  localparam int RECIP_10   = 52429;         // ceil(2^19 / 10)
  localparam int RECIP_SH   = 19;
  localparam int RECIP_W    = 33;
  localparam int HI_THRESH  = 3276;
  localparam int LO_THRESH  = 819;

  localparam int DELTA_MAX  = 131071;
  localparam int DELTA_MIN  = -131072;
  localparam int PWM_MAX    = 255;

  typedef enum logic [PHASE_W-1:0] {
    PHASE_JOLT  = 2'd0,
    PHASE_DRIVE = 2'd1,
    PHASE_STOP  = 2'd2
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_BASE   = 3'd0,
    CFG_RIGHT_BASE  = 3'd1,
    CFG_LEFT_GAIN   = 3'd2,
    CFG_RIGHT_GAIN  = 3'd3,
    CFG_OFFSET      = 3'd4,
    CFG_LEFT_JOLT   = 3'd5,
    CFG_RIGHT_JOLT  = 3'd6,
    CFG_RUN_STEPS   = 3'd7
  } cfg_reg_t;

  localparam logic [BASE_W-1:0]          RST_LEFT_BASE  = 16'd27443;
  localparam logic [BASE_W-1:0]          RST_RIGHT_BASE = 16'd23230;
  localparam logic signed [GAIN_W-1:0]   RST_LEFT_GAIN  = 12'sd404;
  localparam logic signed [GAIN_W-1:0]   RST_RIGHT_GAIN = 12'sd448;
  localparam logic signed [OFFSET_W-1:0] RST_OFFSET     = -8'sd4;
  localparam logic [PWM_W-1:0]           RST_LEFT_JOLT  = 8'd240;
  localparam logic [PWM_W-1:0]           RST_RIGHT_JOLT = 8'd200;
  localparam logic [TICK_W-1:0]          RST_RUN_STEPS  = 10'd200;

endpackage

// ----- hdl/ddsc_in_if.sv -----
`timescale 1ns / 1ps

interface ddsc_in_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic [ddsc_pkg::SAMPLE_W-1:0]     left_sample;
  logic [ddsc_pkg::SAMPLE_W-1:0]     right_sample;

  modport source (output valid, mode, left_sample, right_sample, input ready);
  modport sink   (input valid, mode, left_sample, right_sample, output ready);
endinterface

// ----- hdl/ddsc_out_if.sv -----
`timescale 1ns / 1ps

interface ddsc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [ddsc_pkg::PWM_W-1:0]           left_pwm;
  logic [ddsc_pkg::PWM_W-1:0]           right_pwm;
  logic signed [ddsc_pkg::DELTA_W-1:0]  wheel_delta;
  logic [ddsc_pkg::PHASE_W-1:0]         phase;
  logic [ddsc_pkg::TICKS_W-1:0]         left_ticks;
  logic [ddsc_pkg::TICKS_W-1:0]         right_ticks;

  modport source (output valid, left_pwm, right_pwm, wheel_delta, phase,
                  left_ticks, right_ticks, input ready);
  modport sink   (input valid, left_pwm, right_pwm, wheel_delta, phase,
                  left_ticks, right_ticks, output ready);
endinterface

// ----- hdl/differential_drive_straight_controller.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Payload                                            Handshake
// in_if    in   mode, left_sample, right_sample                    valid/ready
// out_if   out  left_pwm, right_pwm, wheel_delta, phase, ticks     valid/ready
// cfg_*    in   cfg_index, cfg_wdata                               cfg_we
//
// One item per cycle while no result waits at out_if; each beat passes the stages below.
// Stages: input reg, encoder/tick update, delta, gain multiply, pwm clamp.
// The whole pipe moves as one: it stalls only while a result waits at out_if.
// Synchronous active-low reset clears state and valids and reloads the config registers.
module differential_drive_straight_controller #(
  parameter int COUNT_BITS = ddsc_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ddsc_in_if.sink                         in_if,
  ddsc_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [ddsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ddsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int WIDE_W = (COUNT_BITS + 2 > ddsc_pkg::DELTA_W) ?
                          COUNT_BITS + 2 : ddsc_pkg::DELTA_W;
  localparam int PROD_W = ddsc_pkg::GAIN_W + ddsc_pkg::DELTA_W;
  localparam int PSUM_W = PROD_W + 2;

  // configuration
  logic [ddsc_pkg::BASE_W-1:0]          lbase_r, rbase_r;
  logic signed [ddsc_pkg::GAIN_W-1:0]   lgain_r, rgain_r;
  logic signed [ddsc_pkg::OFFSET_W-1:0] offset_r;
  logic [ddsc_pkg::PWM_W-1:0]           ljolt_r, rjolt_r;
  logic [ddsc_pkg::TICK_W-1:0]          run_steps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lbase_r     <= ddsc_pkg::RST_LEFT_BASE;
      rbase_r     <= ddsc_pkg::RST_RIGHT_BASE;
      lgain_r     <= ddsc_pkg::RST_LEFT_GAIN;
      rgain_r     <= ddsc_pkg::RST_RIGHT_GAIN;
      offset_r    <= ddsc_pkg::RST_OFFSET;
      ljolt_r     <= ddsc_pkg::RST_LEFT_JOLT;
      rjolt_r     <= ddsc_pkg::RST_RIGHT_JOLT;
      run_steps_r <= ddsc_pkg::RST_RUN_STEPS;
    end else if (cfg_we) begin
      unique case (ddsc_pkg::cfg_reg_t'(cfg_index))
        ddsc_pkg::CFG_LEFT_BASE:  lbase_r     <= cfg_wdata[ddsc_pkg::BASE_W-1:0];
        ddsc_pkg::CFG_RIGHT_BASE: rbase_r     <= cfg_wdata[ddsc_pkg::BASE_W-1:0];
        ddsc_pkg::CFG_LEFT_GAIN:  lgain_r     <= cfg_wdata[ddsc_pkg::GAIN_W-1:0];
        ddsc_pkg::CFG_RIGHT_GAIN: rgain_r     <= cfg_wdata[ddsc_pkg::GAIN_W-1:0];
        ddsc_pkg::CFG_OFFSET:     offset_r    <= cfg_wdata[ddsc_pkg::OFFSET_W-1:0];
        ddsc_pkg::CFG_LEFT_JOLT:  ljolt_r     <= cfg_wdata[ddsc_pkg::PWM_W-1:0];
        ddsc_pkg::CFG_RIGHT_JOLT: rjolt_r     <= cfg_wdata[ddsc_pkg::PWM_W-1:0];
        ddsc_pkg::CFG_RUN_STEPS:  run_steps_r <= cfg_wdata[ddsc_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_r;
  assign adv         = !out_valid_r || out_if.ready;
  assign in_if.ready = adv;

  // S0: input register
  logic                          v0_r, mode0_r;
  logic [ddsc_pkg::SAMPLE_W-1:0] ls0_r, rs0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (adv) v0_r <= in_if.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode0_r <= in_if.mode;
      ls0_r   <= in_if.left_sample;
      rs0_r   <= in_if.right_sample;
    end
  end

  // S1: encoder state and tick counter
  logic                   wheel_en;
  logic [COUNT_BITS-1:0]  lcount, rcount;
  assign wheel_en = adv && v0_r;

  ddsc_wheel #(.COUNT_BITS(COUNT_BITS)) u_left (
    .clk(clk), .rst_n(rst_n), .en(wheel_en), .sample(ls0_r), .count(lcount)
  );
  ddsc_wheel #(.COUNT_BITS(COUNT_BITS)) u_right (
    .clk(clk), .rst_n(rst_n), .en(wheel_en), .sample(rs0_r), .count(rcount)
  );

  logic [ddsc_pkg::TICK_W-1:0] tick_r, tick_nxt;
  ddsc_pkg::phase_t            phase_nxt, phase1_r;
  logic                        v1_r;

  always_comb begin
    tick_nxt = tick_r;
    if (tick_r < ddsc_pkg::TICK_W'(ddsc_pkg::JOLT_TICKS)) begin
      phase_nxt = ddsc_pkg::PHASE_JOLT;
      tick_nxt  = tick_r + ddsc_pkg::TICK_W'(1);
    end else if (tick_r < run_steps_r) begin
      phase_nxt = ddsc_pkg::PHASE_DRIVE;
      tick_nxt  = tick_r + ddsc_pkg::TICK_W'(1);
    end else begin
      phase_nxt = ddsc_pkg::PHASE_STOP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      v1_r   <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r && mode0_r;
      if (v0_r && mode0_r) tick_r <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) phase1_r <= phase_nxt;
  end

  // S2: count difference; wheel counters still hold this item's values here
  logic signed [WIDE_W-1:0]            diff;
  logic signed [ddsc_pkg::DELTA_W-1:0] delta_nxt, delta2_r;
  logic [COUNT_BITS+ddsc_pkg::TICKS_W-1:0] lext, rext;
  logic [ddsc_pkg::TICKS_W-1:0]        lt2_r, rt2_r;
  ddsc_pkg::phase_t                    phase2_r;
  logic                                v2_r;

  always_comb begin
    diff = WIDE_W'($signed({2'b00, lcount})) - WIDE_W'($signed({2'b00, rcount}))
         + WIDE_W'(offset_r);
    if (diff > WIDE_W'(ddsc_pkg::DELTA_MAX))
      delta_nxt = ddsc_pkg::DELTA_W'(ddsc_pkg::DELTA_MAX);
    else if (diff < WIDE_W'(ddsc_pkg::DELTA_MIN))
      delta_nxt = ddsc_pkg::DELTA_W'(ddsc_pkg::DELTA_MIN);
    else
      delta_nxt = diff[ddsc_pkg::DELTA_W-1:0];
    if (phase1_r != ddsc_pkg::PHASE_DRIVE) delta_nxt = '0;
    lext = {{ddsc_pkg::TICKS_W{1'b0}}, lcount};
    rext = {{ddsc_pkg::TICKS_W{1'b0}}, rcount};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      delta2_r <= delta_nxt;
      phase2_r <= phase1_r;
      lt2_r    <= lext[ddsc_pkg::TICKS_W-1:0];
      rt2_r    <= rext[ddsc_pkg::TICKS_W-1:0];
    end
  end

  // S3: gain products
  logic signed [PROD_W-1:0]            lprod3_r, rprod3_r;
  logic signed [ddsc_pkg::DELTA_W-1:0] delta3_r;
  logic [ddsc_pkg::TICKS_W-1:0]        lt3_r, rt3_r;
  ddsc_pkg::phase_t                    phase3_r;
  logic                                v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lprod3_r <= PROD_W'(lgain_r) * PROD_W'(delta2_r);
      rprod3_r <= PROD_W'(rgain_r) * PROD_W'(delta2_r);
      delta3_r <= delta2_r;
      phase3_r <= phase2_r;
      lt3_r    <= lt2_r;
      rt3_r    <= rt2_r;
    end
  end

  // S4: Q8.8 sum, floor and clamp; jolt phase takes the jolt duty, stop gives zero
  logic signed [PSUM_W-1:0]   lsum, rsum;
  logic [ddsc_pkg::PWM_W-1:0] lpwm, rpwm;

  function automatic logic [ddsc_pkg::PWM_W-1:0] clamp_pwm(
    input logic signed [PSUM_W-1:0] p
  );
    logic signed [PSUM_W-1:0] q;
    q = p >>> 8;
    if (p < 0)
      return '0;
    else if (q > PSUM_W'(ddsc_pkg::PWM_MAX))
      return ddsc_pkg::PWM_W'(ddsc_pkg::PWM_MAX);
    else
      return q[ddsc_pkg::PWM_W-1:0];
  endfunction

  always_comb begin
    lsum = $signed(PSUM_W'(lbase_r)) - PSUM_W'(lprod3_r);
    rsum = $signed(PSUM_W'(rbase_r)) + PSUM_W'(rprod3_r);
    unique case (phase3_r)
      ddsc_pkg::PHASE_JOLT: begin
        lpwm = ljolt_r;
        rpwm = rjolt_r;
      end
      ddsc_pkg::PHASE_DRIVE: begin
        lpwm = clamp_pwm(lsum);
        rpwm = clamp_pwm(rsum);
      end
      default: begin
        lpwm = '0;
        rpwm = '0;
      end
    endcase
  end

  logic [ddsc_pkg::PWM_W-1:0]          lpwm_r, rpwm_r;
  logic signed [ddsc_pkg::DELTA_W-1:0] delta_r;
  logic [ddsc_pkg::PHASE_W-1:0]        phase_r;
  logic [ddsc_pkg::TICKS_W-1:0]        lt_r, rt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lpwm_r  <= lpwm;
      rpwm_r  <= rpwm;
      delta_r <= delta3_r;
      phase_r <= phase3_r;
      lt_r    <= lt3_r;
      rt_r    <= rt3_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.left_pwm    = lpwm_r;
  assign out_if.right_pwm   = rpwm_r;
  assign out_if.wheel_delta = delta_r;
  assign out_if.phase       = phase_r;
  assign out_if.left_ticks  = lt_r;
  assign out_if.right_ticks = rt_r;

endmodule

// ----- hdl/ddsc_wheel.sv -----
`timescale 1ns / 1ps

// One encoder channel: running average, hysteresis level, tick counter.
module ddsc_wheel #(
  parameter int COUNT_BITS = ddsc_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [ddsc_pkg::SAMPLE_W-1:0] sample,
  output logic [COUNT_BITS-1:0]         count
);

  logic [ddsc_pkg::AVG_W-1:0]   avg_r, avg_nxt;
  logic                         level_r, level_nxt;
  logic [COUNT_BITS-1:0]        count_r, count_nxt;
  logic [ddsc_pkg::SUM_W-1:0]   wsum;
  logic [ddsc_pkg::RECIP_W-1:0] recip;
  logic                         flip;

  always_comb begin
    wsum  = ddsc_pkg::SUM_W'(avg_r) * ddsc_pkg::SUM_W'(3)
          + ddsc_pkg::SUM_W'(sample) * ddsc_pkg::SUM_W'(7);
    // floor(wsum/10) via reciprocal, exact for wsum below 43690
    recip   = ddsc_pkg::RECIP_W'(wsum) * ddsc_pkg::RECIP_W'(ddsc_pkg::RECIP_10);
    avg_nxt = recip[ddsc_pkg::RECIP_SH +: ddsc_pkg::AVG_W];
    flip    = (!level_r && (avg_nxt > ddsc_pkg::AVG_W'(ddsc_pkg::HI_THRESH))) ||
              ( level_r && (avg_nxt < ddsc_pkg::AVG_W'(ddsc_pkg::LO_THRESH)));
    level_nxt = level_r ^ flip;
    count_nxt = flip ? count_r + COUNT_BITS'(1) : count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r   <= '0;
      level_r <= 1'b0;
      count_r <= '0;
    end else if (en) begin
      avg_r   <= avg_nxt;
      level_r <= level_nxt;
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

// ----- hdl/ddsc_checker.sv -----
`timescale 1ns / 1ps

module ddsc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [ddsc_pkg::PWM_W-1:0]          out_left_pwm,
  input logic [ddsc_pkg::PWM_W-1:0]          out_right_pwm,
  input logic signed [ddsc_pkg::DELTA_W-1:0] out_wheel_delta,
  input logic [ddsc_pkg::PHASE_W-1:0]        out_phase
);

  // a waiting result beat stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase == ddsc_pkg::PHASE_STOP |->
      out_left_pwm == '0 && out_right_pwm == '0 && out_wheel_delta == '0)
    else $error("stopped phase with nonzero drive");

  a_jolt_delta: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase == ddsc_pkg::PHASE_JOLT |-> out_wheel_delta == '0)
    else $error("jolt phase with nonzero delta");

  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind differential_drive_straight_controller ddsc_checker u_ddsc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_left_pwm    (out_if.left_pwm),
  .out_right_pwm   (out_if.right_pwm),
  .out_wheel_delta (out_if.wheel_delta),
  .out_phase       (out_if.phase)
);

// ----- bench/differential_drive_straight_controller_test.sv -----
`timescale 1ns / 1ps

module differential_drive_straight_controller_test;

  typedef struct {
    logic [ddsc_pkg::AVG_W-1:0]          avg;
    bit                                  high;
    logic [ddsc_pkg::COUNT_BITS_DEF-1:0] count;
  } wheel_model_t;

  typedef struct {
    logic [ddsc_pkg::PWM_W-1:0]          left_pwm;
    logic [ddsc_pkg::PWM_W-1:0]          right_pwm;
    logic signed [ddsc_pkg::DELTA_W-1:0] wheel_delta;
    ddsc_pkg::phase_t                    phase;
    logic [ddsc_pkg::TICKS_W-1:0]        left_ticks;
    logic [ddsc_pkg::TICKS_W-1:0]        right_ticks;
  } drive_result_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [ddsc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ddsc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  ddsc_in_if  in_ch();
  ddsc_out_if out_ch();

  differential_drive_straight_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copies of the registers and the controller state
  logic [ddsc_pkg::BASE_W-1:0]          left_base, right_base;
  logic signed [ddsc_pkg::GAIN_W-1:0]   left_gain, right_gain;
  logic signed [ddsc_pkg::OFFSET_W-1:0] delta_offset;
  logic [ddsc_pkg::PWM_W-1:0]           jolt_duty_l, jolt_duty_r;
  logic [ddsc_pkg::TICK_W-1:0]          run_steps;

  wheel_model_t                 left_enc, right_enc;
  logic [ddsc_pkg::TICK_W-1:0]  tick_count;

  drive_result_t drive_due[$];
  int unsigned   fail_count;
  bit            in_calm, out_calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic wheel_model_t advance_encoder(wheel_model_t e,
      logic [ddsc_pkg::SAMPLE_W-1:0] s);
    int unsigned  sum;
    wheel_model_t n;
    n = e;
    sum = 3 * e.avg + 7 * s;
    n.avg = ddsc_pkg::AVG_W'(sum / 10);
    if ((!n.high && n.avg > ddsc_pkg::HI_THRESH) ||
        (n.high && n.avg < ddsc_pkg::LO_THRESH)) begin
      n.high = !n.high;
      n.count = n.count + 1'b1;
    end
    return n;
  endfunction

  // base -/+ gain*delta in Q8.8, floor to integer duty, clamp to 0..255
  function automatic logic [ddsc_pkg::PWM_W-1:0] duty_from_q88(
      logic [ddsc_pkg::BASE_W-1:0] base, logic signed [ddsc_pkg::GAIN_W-1:0] gain,
      longint delta, bit add);
    longint b, g, p;
    b = base;
    g = gain;
    p = add ? b + g * delta : b - g * delta;
    if (p < 0) return '0;
    p = p / 256;
    return (p > ddsc_pkg::PWM_MAX) ? ddsc_pkg::PWM_W'(ddsc_pkg::PWM_MAX)
                                   : p[ddsc_pkg::PWM_W-1:0];
  endfunction

  function automatic bit controller_step(bit mode, logic [ddsc_pkg::SAMPLE_W-1:0] ls,
      logic [ddsc_pkg::SAMPLE_W-1:0] rs, output drive_result_t r);
    longint d;
    left_enc = advance_encoder(left_enc, ls);
    right_enc = advance_encoder(right_enc, rs);
    r.left_pwm = '0;
    r.right_pwm = '0;
    r.wheel_delta = '0;
    r.phase = ddsc_pkg::PHASE_STOP;
    r.left_ticks = left_enc.count[ddsc_pkg::TICKS_W-1:0];
    r.right_ticks = right_enc.count[ddsc_pkg::TICKS_W-1:0];
    if (!mode) return 1'b0;
    if (tick_count < ddsc_pkg::JOLT_TICKS) begin
      r.phase = ddsc_pkg::PHASE_JOLT;
      r.left_pwm = jolt_duty_l;
      r.right_pwm = jolt_duty_r;
      tick_count = tick_count + 1'b1;
    end else if (tick_count < run_steps) begin
      r.phase = ddsc_pkg::PHASE_DRIVE;
      d = longint'(left_enc.count) - longint'(right_enc.count) + delta_offset;
      if (d > ddsc_pkg::DELTA_MAX) d = ddsc_pkg::DELTA_MAX;
      if (d < ddsc_pkg::DELTA_MIN) d = ddsc_pkg::DELTA_MIN;
      r.wheel_delta = d[ddsc_pkg::DELTA_W-1:0];
      r.left_pwm = duty_from_q88(left_base, left_gain, d, 1'b0);
      r.right_pwm = duty_from_q88(right_base, right_gain, d, 1'b1);
      tick_count = tick_count + 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic send_sample(bit mode, logic [ddsc_pkg::SAMPLE_W-1:0] ls,
      logic [ddsc_pkg::SAMPLE_W-1:0] rs);
    int unsigned   gap;
    drive_result_t r;
    gap = in_calm ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.left_sample <= ls;
    in_ch.right_sample <= rs;
    do @(posedge clk); while (!in_ch.ready);
    if (controller_step(mode, ls, rs, r)) drive_due.push_back(r);
  endtask

  // Drop valid, drain the pipe and let any sample-only beats flush out
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (drive_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(ddsc_pkg::cfg_reg_t idx, logic [ddsc_pkg::CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      ddsc_pkg::CFG_LEFT_BASE:  left_base = v[ddsc_pkg::BASE_W-1:0];
      ddsc_pkg::CFG_RIGHT_BASE: right_base = v[ddsc_pkg::BASE_W-1:0];
      ddsc_pkg::CFG_LEFT_GAIN:  left_gain = v[ddsc_pkg::GAIN_W-1:0];
      ddsc_pkg::CFG_RIGHT_GAIN: right_gain = v[ddsc_pkg::GAIN_W-1:0];
      ddsc_pkg::CFG_OFFSET:     delta_offset = v[ddsc_pkg::OFFSET_W-1:0];
      ddsc_pkg::CFG_LEFT_JOLT:  jolt_duty_l = v[ddsc_pkg::PWM_W-1:0];
      ddsc_pkg::CFG_RIGHT_JOLT: jolt_duty_r = v[ddsc_pkg::PWM_W-1:0];
      ddsc_pkg::CFG_RUN_STEPS:  run_steps = v[ddsc_pkg::TICK_W-1:0];
      default: ;
    endcase
  endtask

  // Extremes half the time; bits above the register width are junk
  function automatic logic [ddsc_pkg::CFG_DATA_W-1:0] pick_field(int unsigned w, bit sgn);
    logic [ddsc_pkg::CFG_DATA_W-1:0] v, mask;
    mask = ddsc_pkg::CFG_DATA_W'((1 << w) - 1);
    case ($urandom_range(0, 3))
      0:       v = sgn ? ddsc_pkg::CFG_DATA_W'(1 << (w - 1)) : '0;
      1:       v = sgn ? ddsc_pkg::CFG_DATA_W'((1 << (w - 1)) - 1) : mask;
      default: v = ddsc_pkg::CFG_DATA_W'($urandom);
    endcase
    return (v & mask) | (ddsc_pkg::CFG_DATA_W'($urandom) & ~mask);
  endfunction

  task automatic randomize_config();
    int unsigned steps;
    write_reg(ddsc_pkg::CFG_LEFT_BASE, pick_field(ddsc_pkg::BASE_W, 1'b0));
    write_reg(ddsc_pkg::CFG_RIGHT_BASE, pick_field(ddsc_pkg::BASE_W, 1'b0));
    write_reg(ddsc_pkg::CFG_LEFT_GAIN, pick_field(ddsc_pkg::GAIN_W, 1'b1));
    write_reg(ddsc_pkg::CFG_RIGHT_GAIN, pick_field(ddsc_pkg::GAIN_W, 1'b1));
    write_reg(ddsc_pkg::CFG_OFFSET, pick_field(ddsc_pkg::OFFSET_W, 1'b1));
    write_reg(ddsc_pkg::CFG_LEFT_JOLT, pick_field(ddsc_pkg::PWM_W, 1'b0));
    write_reg(ddsc_pkg::CFG_RIGHT_JOLT, pick_field(ddsc_pkg::PWM_W, 1'b0));
    // the tick counter never goes back, so keep most settings ahead of it
    case ($urandom_range(0, 7))
      0:       steps = 0;
      1, 2:    steps = 1023;
      default: steps = tick_count + $urandom_range(0, 200);
    endcase
    if (steps > 1023) steps = 1023;
    write_reg(ddsc_pkg::CFG_RUN_STEPS,
              ddsc_pkg::CFG_DATA_W'(steps | ($urandom & ~32'h3ff)));
  endtask

  // Mostly high/low sample runs that swing the encoder averages across the
  // hysteresis band, with a sprinkle of arbitrary samples
  task automatic random_traffic(int unsigned n);
    bit                            left_hi, right_hi;
    int unsigned                   left_run, right_run;
    logic [ddsc_pkg::SAMPLE_W-1:0] ls, rs;
    left_hi = bit'($urandom_range(0, 1));
    right_hi = bit'($urandom_range(0, 1));
    left_run = $urandom_range(1, 6);
    right_run = $urandom_range(1, 6);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) begin
        ls = ddsc_pkg::SAMPLE_W'($urandom);
        rs = ddsc_pkg::SAMPLE_W'($urandom);
      end else begin
        ls = ddsc_pkg::SAMPLE_W'(left_hi ? $urandom_range(3400, 4095)
                                         : $urandom_range(0, 700));
        rs = ddsc_pkg::SAMPLE_W'(right_hi ? $urandom_range(3400, 4095)
                                          : $urandom_range(0, 700));
        left_run = left_run - 1;
        right_run = right_run - 1;
        if (left_run == 0) begin
          left_hi = !left_hi;
          left_run = $urandom_range(1, 6);
        end
        if (right_run == 0) begin
          right_hi = !right_hi;
          right_run = $urandom_range(1, 6);
        end
      end
      send_sample($urandom_range(0, 3) == 0, ls, rs);
    end
  endtask

  // run_steps of zero: jolt ticks still happen, then the motors stop
  task automatic test_short_run();
    write_reg(ddsc_pkg::CFG_RUN_STEPS, 16'd0);
    write_reg(ddsc_pkg::CFG_LEFT_JOLT, 16'd255);
    write_reg(ddsc_pkg::CFG_RIGHT_JOLT, 16'd0);
    send_sample(1'b0, 12'd0, 12'd4095);
    send_sample(1'b1, 12'd4095, 12'd0);
    send_sample(1'b1, 12'd4095, 12'd4095);
    send_sample(1'b1, 12'd0, 12'd0);
    send_sample(1'b1, 12'd4095, 12'd0);
    settle();
  endtask

  task automatic test_drive_extremes();
    write_reg(ddsc_pkg::CFG_RUN_STEPS, 16'd1023);
    write_reg(ddsc_pkg::CFG_LEFT_BASE, 16'hffff);
    write_reg(ddsc_pkg::CFG_RIGHT_BASE, 16'h0000);
    write_reg(ddsc_pkg::CFG_LEFT_GAIN, 16'h07ff);
    write_reg(ddsc_pkg::CFG_RIGHT_GAIN, 16'h0800);
    write_reg(ddsc_pkg::CFG_OFFSET, 16'h007f);
    for (int i = 0; i < 6; i++) send_sample(1'b1, (i & 2) ? 12'd0 : 12'd4095, 12'd0);
    settle();
    write_reg(ddsc_pkg::CFG_LEFT_BASE, 16'h0000);
    write_reg(ddsc_pkg::CFG_RIGHT_BASE, 16'hffff);
    write_reg(ddsc_pkg::CFG_LEFT_GAIN, 16'h0800);
    write_reg(ddsc_pkg::CFG_RIGHT_GAIN, 16'h07ff);
    write_reg(ddsc_pkg::CFG_OFFSET, 16'h0080);
    for (int i = 0; i < 8; i++) send_sample(1'b1, 12'd0, (i & 2) ? 12'd0 : 12'd4095);
    settle();
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < 6; i++) begin
      randomize_config();
      in_calm = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      random_traffic(240);
      settle();
    end
    in_calm = 1'b0;
    out_calm = 1'b0;
  endtask

  // Stop a few ticks ahead, then lift the limit so driving picks up again
  task automatic test_stop_and_resume();
    int unsigned steps;
    steps = tick_count + 3;
    if (steps > 1023) steps = 1023;
    write_reg(ddsc_pkg::CFG_RUN_STEPS, ddsc_pkg::CFG_DATA_W'(steps));
    random_traffic(30);
    settle();
    write_reg(ddsc_pkg::CFG_RUN_STEPS, 16'd1023);
    random_traffic(30);
    settle();
  endtask

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  initial begin : result_check
    drive_result_t want;
    int unsigned   stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = out_calm ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        // sometimes hold the beat back once it shows up
        if ($urandom_range(0, 1)) do @(posedge clk); while (!out_ch.valid);
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (drive_due.size() == 0) begin
        $error("unexpected result beat: left_pwm %0d right_pwm %0d phase %0d",
               out_ch.left_pwm, out_ch.right_pwm, out_ch.phase);
        fail_count++;
      end else begin
        want = drive_due.pop_front();
        check_field("left_pwm", want.left_pwm, out_ch.left_pwm);
        check_field("right_pwm", want.right_pwm, out_ch.right_pwm);
        check_field("wheel_delta", want.wheel_delta, out_ch.wheel_delta);
        check_field("phase", want.phase, out_ch.phase);
        check_field("left_ticks", want.left_ticks, out_ch.left_ticks);
        check_field("right_ticks", want.right_ticks, out_ch.right_ticks);
      end
    end
  end

  initial begin : stimulus
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= 1'b0;
    in_ch.left_sample <= '0;
    in_ch.right_sample <= '0;
    fail_count = 0;
    in_calm = 1'b0;
    out_calm = 1'b0;
    left_base = ddsc_pkg::RST_LEFT_BASE;
    right_base = ddsc_pkg::RST_RIGHT_BASE;
    left_gain = ddsc_pkg::RST_LEFT_GAIN;
    right_gain = ddsc_pkg::RST_RIGHT_GAIN;
    delta_offset = ddsc_pkg::RST_OFFSET;
    jolt_duty_l = ddsc_pkg::RST_LEFT_JOLT;
    jolt_duty_r = ddsc_pkg::RST_RIGHT_JOLT;
    run_steps = ddsc_pkg::RST_RUN_STEPS;
    left_enc = '{avg: '0, high: 1'b0, count: '0};
    right_enc = '{avg: '0, high: 1'b0, count: '0};
    tick_count = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_run();
    test_drive_extremes();
    test_random_traffic();
    test_stop_and_resume();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
